### hdl/hcb_pkg.sv
// hcb_pkg: shared types and constants of the huffman code builder
// no dependencies
package hcb_pkg;
	localparam int SYM_BITS = 8;
	localparam int LEN_BITS = 6;
	localparam int CODE_BITS = 63;
	localparam int NW_BITS = 30;
	localparam logic [NW_BITS-1:0] NW_MAX = {NW_BITS{1'b1}};

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SCAN_A,
		ST_SCAN_B,
		ST_MERGE,
		ST_WALK_INIT,
		ST_WALK_RD,
		ST_WALK_STEP,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic take_a;
		logic take_b;
		logic merge;
		logic walk_init;
		logic walk_rd;
		logic walk_step;
		logic emit;
		logic clear_step;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic found;
		logic more_live;
		logic node_full;
		logic walk_done;
		logic last_leaf;
		logic clear_done;
		logic empty;
	} sts_t;
endpackage

### hdl/hcb_ctrl.sv
// hcb_ctrl: sequencing state machine of the huffman code builder
// depends on hcb_pkg
module hcb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_fire,
	input  logic           in_last,
	input  logic           out_fire,
	input  hcb_pkg::sts_t  sts,
	output hcb_pkg::cmd_t  cmd,
	output logic           load_ready,
	output logic           out_valid
);
	hcb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= hcb_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		load_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			hcb_pkg::ST_LOAD: begin
				load_ready = 1'b1;
				if (in_fire) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.scan_start = 1'b1;
						state_d = hcb_pkg::ST_SCAN_A;
					end
				end
			end
			hcb_pkg::ST_SCAN_A: begin
				if (sts.empty) state_d = hcb_pkg::ST_CLEAR;
				else if (!sts.more_live || sts.node_full) state_d = hcb_pkg::ST_WALK_INIT;
				else if (sts.scan_done) begin
					cmd.take_a = 1'b1;
					cmd.scan_start = 1'b1;
					state_d = hcb_pkg::ST_SCAN_B;
				end else cmd.scan_step = 1'b1;
			end
			hcb_pkg::ST_SCAN_B: begin
				if (sts.scan_done) begin
					cmd.take_b = 1'b1;
					state_d = hcb_pkg::ST_MERGE;
				end else cmd.scan_step = 1'b1;
			end
			hcb_pkg::ST_MERGE: begin
				cmd.merge = 1'b1;
				cmd.scan_start = 1'b1;
				state_d = hcb_pkg::ST_SCAN_A;
			end
			hcb_pkg::ST_WALK_INIT: begin
				cmd.walk_init = 1'b1;
				state_d = hcb_pkg::ST_WALK_RD;
			end
			hcb_pkg::ST_WALK_RD: begin
				cmd.walk_rd = 1'b1;
				state_d = hcb_pkg::ST_WALK_STEP;
			end
			hcb_pkg::ST_WALK_STEP: begin
				if (sts.walk_done) state_d = hcb_pkg::ST_EMIT;
				else begin
					cmd.walk_step = 1'b1;
					state_d = hcb_pkg::ST_WALK_RD;
				end
			end
			hcb_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_fire) begin
					cmd.emit = 1'b1;
					state_d = sts.last_leaf ? hcb_pkg::ST_CLEAR : hcb_pkg::ST_WALK_RD;
				end
			end
			hcb_pkg::ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) state_d = hcb_pkg::ST_LOAD;
			end
			default: state_d = hcb_pkg::ST_LOAD;
		endcase
	end

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> state_q == hcb_pkg::ST_EMIT) else $error("emit outside emit state");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == hcb_pkg::ST_LOAD) else $error("load while busy");
	a_merge_after_b: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hcb_pkg::ST_MERGE |-> $past(cmd.take_b)) else $error("merge without second pick");
endmodule

### hdl/hcb_datapath.sv
// hcb_datapath: node stores, min-search unit, code walker
// depends on hcb_pkg
module hcb_datapath #(
	parameter int MAX_SYMBOLS = 64,
	parameter int WEIGHT_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hcb_pkg::cmd_t                 cmd,
	input  logic [hcb_pkg::SYM_BITS-1:0]  in_symbol,
	input  logic [WEIGHT_BITS-1:0]        in_weight,
	output hcb_pkg::sts_t                 sts,
	output logic [hcb_pkg::SYM_BITS-1:0]  out_symbol,
	output logic [hcb_pkg::LEN_BITS-1:0]  code_length,
	output logic [hcb_pkg::CODE_BITS-1:0] code_bits,
	output logic                          last_code
);
	localparam int SLOTS = 2 * MAX_SYMBOLS - 1;
	localparam int IW = $clog2(SLOTS + 1);
	localparam int LW = $clog2(MAX_SYMBOLS);
	localparam int CW = $clog2(MAX_SYMBOLS + 1);
	localparam int NW = hcb_pkg::NW_BITS;

	logic [hcb_pkg::SYM_BITS-1:0] sym_mem [MAX_SYMBOLS];
	logic [NW-1:0] wt_mem [SLOTS];
	logic [IW-1:0] par_mem [SLOTS];
	logic          rt_mem [SLOTS];
	logic [SLOTS-1:0] live_q;

	logic [CW-1:0] cnt_q;
	logic [IW-1:0] used_q, live_n_q, scan_q, best_q, a_q, k_q, node_q, clr_q;
	logic          best_ok_q;
	logic [NW-1:0] best_w_q, a_w_q;
	logic [NW-1:0] wt_rd_q;
	logic          wt_live_q;
	logic [IW-1:0] par_rd_q;
	logic          rt_rd_q;
	logic [hcb_pkg::LEN_BITS-1:0] len_q;
	logic [hcb_pkg::CODE_BITS-1:0] bits_q;
	logic [hcb_pkg::SYM_BITS-1:0] sym_rd_q;
	logic          rd_ok_q;
	logic [NW:0]   sum;
	logic [IW-1:0] root;

	assign sum = {1'b0, a_w_q} + {1'b0, best_w_q};
	assign root = used_q - IW'(1);

	// pipelined scan: read at scan_q into a register, compare in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.load && cnt_q < CW'(MAX_SYMBOLS)) begin
			sym_mem[cnt_q[LW-1:0]] <= in_symbol;
			wt_mem[IW'(cnt_q)] <= NW'(in_weight);
			rt_mem[IW'(cnt_q)] <= 1'b0;
		end
		if (cmd.merge) begin
			wt_mem[used_q] <= (sum > {1'b0, hcb_pkg::NW_MAX}) ? hcb_pkg::NW_MAX : sum[NW-1:0];
			par_mem[a_q] <= used_q;
			rt_mem[a_q] <= 1'b0;
		end
		if (cmd.take_b) begin
			par_mem[best_q] <= used_q;
			rt_mem[best_q] <= 1'b1;
		end
		wt_rd_q <= wt_mem[scan_q];
		par_rd_q <= par_mem[node_q];
		rt_rd_q <= rt_mem[node_q];
		sym_rd_q <= sym_mem[k_q[LW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			cnt_q <= '0;
			used_q <= '0;
			live_n_q <= '0;
			scan_q <= '0;
			best_q <= '0;
			best_ok_q <= 1'b0;
			best_w_q <= '0;
			a_q <= '0;
			a_w_q <= '0;
			wt_live_q <= 1'b0;
			rd_ok_q <= 1'b0;
			k_q <= '0;
			node_q <= '0;
			len_q <= '0;
			bits_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.load && cnt_q < CW'(MAX_SYMBOLS)) begin
				live_q[IW'(cnt_q)] <= 1'b1;
				cnt_q <= cnt_q + CW'(1);
				used_q <= IW'(cnt_q) + IW'(1);
				live_n_q <= IW'(cnt_q) + IW'(1);
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
				rd_ok_q <= 1'b0;
				best_ok_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (scan_q < used_q) scan_q <= scan_q + IW'(1);
				rd_ok_q <= scan_q < used_q;
				wt_live_q <= live_q[scan_q];
				if (rd_ok_q && wt_live_q && (!best_ok_q || wt_rd_q < best_w_q)) begin
					best_ok_q <= 1'b1;
					best_w_q <= wt_rd_q;
					best_q <= scan_q - IW'(1);
				end
			end
			if (cmd.take_a) begin
				a_q <= best_q;
				a_w_q <= best_w_q;
				live_q[best_q] <= 1'b0;
			end
			if (cmd.take_b) live_q[best_q] <= 1'b0;
			if (cmd.merge) begin
				live_q[used_q] <= 1'b1;
				used_q <= used_q + IW'(1);
				live_n_q <= live_n_q - IW'(1);
			end
			if (cmd.walk_init) begin
				k_q <= '0;
				node_q <= '0;
				len_q <= '0;
				bits_q <= '0;
			end
			if (cmd.walk_step) begin
				if (rt_rd_q) bits_q <= bits_q | (hcb_pkg::CODE_BITS'(1) << len_q);
				len_q <= len_q + hcb_pkg::LEN_BITS'(1);
				node_q <= par_rd_q;
			end
			if (cmd.emit) begin
				k_q <= k_q + IW'(1);
				node_q <= k_q + IW'(1);
				len_q <= '0;
				bits_q <= '0;
			end
			if (cmd.clear_step) begin
				live_q <= '0;
				cnt_q <= '0;
				clr_q <= '0;
			end
		end
	end

	// scan ends once the pipeline has drained the last slot
	assign sts.scan_done = (scan_q >= used_q) && !rd_ok_q;
	assign sts.found = best_ok_q;
	assign sts.more_live = live_n_q > IW'(1);
	assign sts.node_full = used_q >= IW'(SLOTS);
	assign sts.walk_done = (node_q == root) || (len_q == hcb_pkg::LEN_BITS'(hcb_pkg::CODE_BITS));
	assign sts.last_leaf = k_q == IW'(cnt_q) - IW'(1);
	assign sts.clear_done = clr_q == '0;
	assign sts.empty = cnt_q == '0;

	assign out_symbol = sym_rd_q;
	assign code_length = len_q;
	assign code_bits = bits_q;
	assign last_code = sts.last_leaf;

	a_take_found: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take_a || cmd.take_b) |-> best_ok_q) else $error("pick with no live node");
	a_merge_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.merge |-> used_q < IW'(SLOTS)) else $error("node store overflow");
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |=> len_q != '0) else $error("length wrapped");
endmodule

### hdl/huffman_code_builder.sv
// Huffman code builder. Symbols load one item per cycle; the item with tlast
// starts the build. Each of the n-1 merges runs two sequential min-searches over
// the used node slots (used growing from n to 2n-2) through the registered
// weight-store read port. A walk-init state then starts the walk; each emitted
// code is walked from its leaf up to the root with alternating parent reads and
// steps, and a clear state cleans up after the last code is taken; no
// item is accepted until the last code has gone out.
// depends on hcb_pkg, hcb_ctrl, hcb_datapath
module huffman_code_builder #(
	parameter int MAX_SYMBOLS = 64,
	parameter int WEIGHT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // symbol[7:0], weight[31:8]
	input  logic        s_axis_tlast,   // final_symbol
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // out_symbol[7:0], code_length[13:8], code_bits[76:14]
	output logic        m_axis_tlast    // last_code
);
	hcb_pkg::cmd_t cmd;
	hcb_pkg::sts_t sts;
	logic in_fire, out_fire;
	logic [WEIGHT_BITS-1:0] in_weight;
	logic [hcb_pkg::SYM_BITS-1:0] out_symbol;
	logic [hcb_pkg::LEN_BITS-1:0] code_length;
	logic [hcb_pkg::CODE_BITS-1:0] code_bits;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign in_weight = WEIGHT_BITS'(s_axis_tdata[31:8]);

	hcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_axis_tlast),
		.out_fire(out_fire), .sts(sts), .cmd(cmd), .load_ready(s_axis_tready),
		.out_valid(m_axis_tvalid)
	);

	hcb_datapath #(.MAX_SYMBOLS(MAX_SYMBOLS), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_symbol(s_axis_tdata[7:0]),
		.in_weight(in_weight), .sts(sts), .out_symbol(out_symbol),
		.code_length(code_length), .code_bits(code_bits), .last_code(m_axis_tlast)
	);

	assign m_axis_tdata = {3'b000, code_bits, code_length, out_symbol};
endmodule

### tb/huffman_code_builder_tb.sv
// huffman_code_builder_tb: self-checking testbench of the huffman code builder
// drives symbol runs on the input stream and checks each emitted code against
// an in-bench tree builder; depends on hcb_pkg and huffman_code_builder
module huffman_code_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SYM = 64;
	localparam int SLOTS = 2 * MAX_SYM - 1;
	localparam int IDLE_LIMIT = 200000;

	typedef struct packed {
		logic [hcb_pkg::SYM_BITS-1:0] sym;
		logic [hcb_pkg::LEN_BITS-1:0] len;
		logic [hcb_pkg::CODE_BITS-1:0] bits;
		logic last;
	} code_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic m_axis_tlast;

	huffman_code_builder u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tree builder state
	logic [hcb_pkg::SYM_BITS-1:0] leaf_sym [MAX_SYM];
	logic [hcb_pkg::NW_BITS-1:0] nw [SLOTS];
	logic [6:0] npar [SLOTS];
	logic nright [SLOTS];
	logic nlive [SLOTS];
	int loaded = 0;

	code_t expected_codes [$];
	int errors = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int rx_stall = 0;
	bit quiet = 0;

	function automatic int min_live(int used);
		int best;
		best = -1;
		for (int i = 0; i < used; i++)
			if (nlive[i] && (best < 0 || nw[i] < nw[best])) best = i;
		return best;
	endfunction

	task automatic predict_item(logic [7:0] sym, logic [23:0] w, logic fin);
		int used, live, a, b, node;
		logic [hcb_pkg::NW_BITS:0] sum;
		code_t c;
		if (loaded < MAX_SYM) begin
			leaf_sym[loaded] = sym;
			nw[loaded] = hcb_pkg::NW_BITS'(w);
			nlive[loaded] = 1'b1;
			npar[loaded] = '0;
			nright[loaded] = 1'b0;
			loaded++;
		end
		if (!fin) return;
		used = loaded;
		live = loaded;
		while (live > 1 && used < SLOTS) begin
			a = min_live(used);
			nlive[a] = 1'b0;
			b = min_live(used);
			nlive[b] = 1'b0;
			sum = nw[a] + nw[b];
			nw[used] = (sum > hcb_pkg::NW_MAX) ? hcb_pkg::NW_MAX
				: sum[hcb_pkg::NW_BITS-1:0];
			nlive[used] = 1'b1;
			npar[a] = 7'(used);
			nright[a] = 1'b0;
			npar[b] = 7'(used);
			nright[b] = 1'b1;
			used++;
			live--;
		end
		for (int k = 0; k < loaded; k++) begin
			c = '0;
			node = k;
			while (node != used - 1 && c.len < 63) begin
				if (nright[node]) c.bits[c.len] = 1'b1;
				c.len++;
				node = npar[node];
			end
			c.sym = leaf_sym[k];
			c.last = (k == loaded - 1);
			expected_codes.push_back(c);
		end
		for (int i = 0; i < SLOTS; i++) nlive[i] = 1'b0;
		loaded = 0;
	endtask

	task automatic send_item(logic [7:0] sym, logic [23:0] w, logic fin);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {w, sym};
		s_axis_tlast <= fin;
		predict_item(sym, w, fin);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_run(int n, int wmode);
		logic [23:0] w;
		for (int i = 0; i < n; i++) begin
			case (wmode)
				0: w = 24'($urandom_range(0, 15));
				1: w = 24'($urandom);
				2: w = 24'hFFFFFF;
				default: w = 24'(1) << $urandom_range(0, 23);
			endcase
			send_item(8'($urandom), w, i == n - 1);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// receiver with random stall bursts
	always @(posedge clk) begin
		if (!arst_n || quiet) begin
			m_axis_tready <= 1'b1;
			rx_stall <= 0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			if (rx_stall == 1) m_axis_tready <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			rx_stall <= $urandom_range(1, 6);
		end
	end

	always @(posedge clk) begin
		code_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tdata[76:14], m_axis_tlast};
			if (expected_codes.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected code %h", got);
			end else begin
				want = expected_codes.pop_front();
				if (got !== want || m_axis_tdata[79:77] !== 3'b0) begin
					errors++;
					if (mismatches++ < 10)
						$display({"code mismatch: exp sym %h len %0d bits %h last %b,",
							" got sym %h len %0d bits %h last %b"},
							want.sym, want.len, want.bits, want.last,
							got.sym, got.len, got.bits, got.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_directed();
		send_item(8'h00, 24'h000000, 1'b1);
		send_item(8'hFF, 24'hFFFFFF, 1'b0);
		send_item(8'h01, 24'h000000, 1'b1);
		send_item(8'hA5, 24'h000005, 1'b0);
		send_item(8'h5A, 24'h000005, 1'b0);
		send_item(8'h3C, 24'h000005, 1'b1);
		send_item(8'h11, 24'h000001, 1'b0);
		send_item(8'h22, 24'h000002, 1'b0);
		send_item(8'h11, 24'h000004, 1'b0);
		send_item(8'h44, 24'h000008, 1'b0);
		send_item(8'h55, 24'h000010, 1'b1);
		send_run(3, 2);
		wait_drained();
	endtask

	task automatic test_full_store();
		// full store, then extras past the 64th item dropped, the final item included
		for (int i = 0; i < 66; i++)
			send_item(8'(i), (i < 64) ? 24'(1) << (i % 24) : 24'hABCDEF, i == 65);
		wait_drained();
		send_run(64, 3);
		wait_drained();
	endtask

	task automatic test_random();
		int n;
		for (int r = 0; r < 17; r++) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
			send_run(n, $urandom_range(0, 3));
		end
		wait_drained();
	endtask

	task automatic test_steady();
		quiet = 1;
		for (int r = 0; r < 8; r++) send_run($urandom_range(1, 6), $urandom_range(0, 1));
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_store();
		test_random();
		test_steady();
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end
endmodule
